>>> rtl/sprite_quad_batcher_unit_defines.svh
// assertion macros shared by the sprite quad batcher rtl
`ifndef SPRITE_QUAD_BATCHER_UNIT_DEFINES_SVH
`define SPRITE_QUAD_BATCHER_UNIT_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define SQB_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define SQB_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> rtl/sqb_pkg.sv
// types, constants and tables of the sprite quad batcher
package sqb_pkg;

    localparam int SQB_MAX_BATCH    = 1024;
    localparam int CORDIC_STEPS     = 24;
    localparam int ITER_W           = 5;

    // angle arithmetic in q30, wide enough for the full q4.12 input range
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] NEG_PI_Q30  = -36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] NEG_HALF_PI = -36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic signed [17:0] ONE_Q16     = 18'sd65536;

    typedef enum logic [1:0] {
        REQ_DRAW    = 2'd0,
        REQ_FLUSH   = 2'd1,
        REQ_DISCARD = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FLUSH,
        S_SCALE,
        S_PIVOT,
        S_ROT,
        S_TRIG,
        S_MUL,
        S_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic discard;
        logic emit_flush;
        logic flush_last;
        logic scale;
        logic pivot;
        logic rot_step;
        logic trig;
        logic corner_mul;
        logic emit_vertex;
    } sqb_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        req_t req;
        logic tex_zero;
        logic need_flush;
        logic count_nz;
        logic angle_zero;
        logic rot_done;
        logic out_free;
        logic corner_last;
    } sqb_stat_t;

    // arctangent table in q30
    function automatic logic signed [31:0] atan_q30(input logic [ITER_W-1:0] idx);
        logic signed [31:0] r;
        begin
            case (idx)
                5'd0:    r = 32'sh3243F6A8;
                5'd1:    r = 32'sh1DAC6705;
                5'd2:    r = 32'sh0FADBAFC;
                5'd3:    r = 32'sh07F56EA6;
                5'd4:    r = 32'sh03FEAB76;
                5'd5:    r = 32'sh01FFD55B;
                5'd6:    r = 32'sh00FFFAAA;
                5'd7:    r = 32'sh007FFF55;
                5'd8:    r = 32'sh003FFFEA;
                5'd9:    r = 32'sh001FFFFD;
                5'd10:   r = 32'sh000FFFFF;
                5'd11:   r = 32'sh0007FFFF;
                5'd12:   r = 32'sh0003FFFF;
                5'd13:   r = 32'sh0001FFFF;
                5'd14:   r = 32'sh0000FFFF;
                5'd15:   r = 32'sh00007FFF;
                5'd16:   r = 32'sh00003FFF;
                5'd17:   r = 32'sh00001FFF;
                5'd18:   r = 32'sh00000FFF;
                5'd19:   r = 32'sh000007FF;
                5'd20:   r = 32'sh000003FF;
                5'd21:   r = 32'sh000001FF;
                5'd22:   r = 32'sh000000FF;
                5'd23:   r = 32'sh0000007F;
                default: r = 32'sh00000000;
            endcase
            return r;
        end
    endfunction

endpackage

>>> rtl/sqb_ctrl.sv
// sequencing state machine of the sprite quad batcher
module sqb_ctrl import sqb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  sqb_stat_t stat,
    output logic      idle,
    output sqb_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        idle       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                idle        = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.req)
                    REQ_FLUSH:
                    begin
                        state_next = stat.count_nz ? S_FLUSH : S_IDLE;
                    end
                    REQ_DISCARD:
                    begin
                        cmd.discard = 1'b1;
                        state_next  = S_IDLE;
                    end
                    REQ_DRAW:
                    begin
                        if (stat.tex_zero)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (stat.need_flush && stat.count_nz)
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            state_next = S_SCALE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                    cmd.flush_last = (stat.req == REQ_FLUSH);
                    state_next     = (stat.req == REQ_FLUSH) ? S_IDLE : S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_PIVOT;
            end
            S_PIVOT:
            begin
                cmd.pivot  = 1'b1;
                state_next = stat.angle_zero ? S_TRIG : S_ROT;
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (stat.rot_done)
                begin
                    state_next = S_TRIG;
                end
            end
            S_TRIG:
            begin
                cmd.trig   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.corner_mul = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_vertex = 1'b1;
                    state_next      = stat.corner_last ? S_IDLE : S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/sqb_datapath.sv
// geometry, cordic, batch state and output register of the sprite quad batcher
module sqb_datapath import sqb_pkg::*;
#(
    parameter int MAX_BATCH = SQB_MAX_BATCH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sqb_cmd_t           cmd,
    output sqb_stat_t          stat,
    input  logic [1:0]         req_type,
    input  logic [15:0]        texture_id,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic [31:0]        size_x,
    input  logic [31:0]        size_y,
    input  logic [31:0]        scale_xy,
    input  logic signed [15:0] origin_x,
    input  logic signed [15:0] origin_y,
    input  logic signed [15:0] angle,
    input  logic [63:0]        uv_rect,
    input  logic [31:0]        color,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic signed [31:0] vert_x,
    output logic signed [31:0] vert_y,
    output logic [15:0]        tex_u,
    output logic [15:0]        tex_v,
    output logic [31:0]        vertex_color,
    output logic [11:0]        vertex_index,
    output logic [15:0]        batch_texture,
    output logic [10:0]        batch_sprites,
    output logic               last
);

    // captured item
    logic [1:0]         req_reg;
    logic [15:0]        tex_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [31:0]        size_x_reg, size_y_reg, scale_reg;
    logic signed [15:0] org_x_reg, org_y_reg, angle_reg;
    logic [63:0]        uv_reg;
    logic [31:0]        color_reg;

    // batch state
    logic [15:0] cur_tex_reg;
    logic [10:0] count_reg;

    // geometry and cordic registers
    logic signed [41:0] sw_reg, sh_reg;
    logic signed [43:0] ox_reg, oy_reg;
    logic signed [35:0] z_reg;
    logic               neg_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic signed [17:0] cos_reg, sin_reg;
    logic [1:0]         corner_reg;
    logic signed [62:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;

    // output register
    logic               out_valid_reg;
    logic               kind_reg, last_reg;
    logic signed [31:0] vx_reg, vy_reg;
    logic [15:0]        tu_reg, tv_reg, btex_reg;
    logic [31:0]        vcol_reg;
    logic [11:0]        vidx_reg;
    logic [10:0]        bspr_reg;

    logic               ld_out;
    logic signed [48:0] prod_sw, prod_sh;
    logic signed [57:0] prod_ox, prod_oy;
    logic signed [35:0] z_init, z_red;
    logic signed [35:0] atan_ext;
    logic signed [33:0] cx_shift, cy_shift;
    logic signed [33:0] cos_sh, sin_sh;
    logic signed [44:0] dx, dy;
    logic signed [63:0] sum_x, sum_y;
    logic signed [48:0] fin_x, fin_y;
    logic [16:0]        u_sum, v_sum;
    logic [15:0]        u_sat, v_sat;

    // scaling, pivot and angle reduction
    assign prod_sw = $signed({1'b0, size_x_reg}) * $signed(scale_reg[15:0]);
    assign prod_sh = $signed({1'b0, size_y_reg}) * $signed(scale_reg[31:16]);
    assign prod_ox = org_x_reg * sw_reg;
    assign prod_oy = org_y_reg * sh_reg;
    assign z_init  = $signed({{2{angle_reg[15]}}, angle_reg, 18'b0});

    always_comb
    begin
        if (z_init > PI_Q30)
        begin
            z_red = z_init - TWO_PI_Q30;
        end
        else if (z_init < NEG_PI_Q30)
        begin
            z_red = z_init + TWO_PI_Q30;
        end
        else
        begin
            z_red = z_init;
        end
    end

    // one cordic rotation per cycle
    assign cx_shift = cx_reg >>> iter_reg;
    assign cy_shift = cy_reg >>> iter_reg;
    assign atan_ext = 36'(atan_q30(iter_reg));
    assign cos_sh   = cx_reg >>> 14;
    assign sin_sh   = cy_reg >>> 14;

    // corner relative to pivot
    assign dx = ((corner_reg == 2'd1) || (corner_reg == 2'd2)) ? 45'(sw_reg) - 45'(ox_reg)
                                                               : -45'(ox_reg);
    assign dy = ((corner_reg == 2'd2) || (corner_reg == 2'd3)) ? 45'(sh_reg) - 45'(oy_reg)
                                                               : -45'(oy_reg);

    // rotated and translated vertex
    assign sum_x = 64'(pxc_reg) - 64'(pys_reg);
    assign sum_y = 64'(pxs_reg) + 64'(pyc_reg);
    assign fin_x = 49'(sum_x >>> 16) + 49'(pos_x_reg);
    assign fin_y = 49'(sum_y >>> 16) + 49'(pos_y_reg);

    // texture coordinates
    assign u_sum = {1'b0, uv_reg[15:0]} + {1'b0, uv_reg[47:32]};
    assign v_sum = {1'b0, uv_reg[31:16]} + {1'b0, uv_reg[63:48]};
    assign u_sat = u_sum[16] ? 16'hFFFF : u_sum[15:0];
    assign v_sat = v_sum[16] ? 16'hFFFF : v_sum[15:0];

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        begin
            if ((v[48:31] != '0) && (v[48:31] != '1))
            begin
                r = v[48] ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
            else
            begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

    // status to the controller
    assign ld_out           = cmd.emit_flush || cmd.emit_vertex;
    assign stat.req         = req_t'(req_reg);
    assign stat.tex_zero    = (tex_reg == '0);
    assign stat.need_flush  = ((cur_tex_reg != '0) && (cur_tex_reg != tex_reg))
                              || (count_reg >= 11'(MAX_BATCH));
    assign stat.count_nz    = (count_reg != '0);
    assign stat.angle_zero  = (angle_reg == '0);
    assign stat.rot_done    = (iter_reg == ITER_W'(CORDIC_STEPS - 1));
    assign stat.out_free    = !out_valid_reg || !out_stall;
    assign stat.corner_last = (corner_reg == 2'd3);

    // item capture and datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg    <= req_type;
            tex_reg    <= texture_id;
            pos_x_reg  <= pos_x;
            pos_y_reg  <= pos_y;
            size_x_reg <= size_x;
            size_y_reg <= size_y;
            scale_reg  <= scale_xy;
            org_x_reg  <= origin_x;
            org_y_reg  <= origin_y;
            angle_reg  <= angle;
            uv_reg     <= uv_rect;
            color_reg  <= color;
        end
        if (cmd.scale)
        begin
            sw_reg <= 42'(prod_sw >>> 8);
            sh_reg <= 42'(prod_sh >>> 8);
            z_reg  <= z_red;
        end
        if (cmd.pivot)
        begin
            ox_reg <= 44'(prod_ox >>> 14);
            oy_reg <= 44'(prod_oy >>> 14);
            cx_reg <= CORDIC_GAIN;
            cy_reg <= '0;
            if (z_reg > HALF_PI_Q30)
            begin
                z_reg   <= z_reg - PI_Q30;
                neg_reg <= 1'b1;
            end
            else if (z_reg < NEG_HALF_PI)
            begin
                z_reg   <= z_reg + PI_Q30;
                neg_reg <= 1'b1;
            end
            else
            begin
                neg_reg <= 1'b0;
            end
        end
        if (cmd.rot_step)
        begin
            if (!z_reg[35])
            begin
                cx_reg <= cx_reg - cy_shift;
                cy_reg <= cy_reg + cx_shift;
                z_reg  <= z_reg - atan_ext;
            end
            else
            begin
                cx_reg <= cx_reg + cy_shift;
                cy_reg <= cy_reg - cx_shift;
                z_reg  <= z_reg + atan_ext;
            end
        end
        if (cmd.trig)
        begin
            if (angle_reg == '0)
            begin
                cos_reg <= ONE_Q16;
                sin_reg <= '0;
            end
            else if (neg_reg)
            begin
                cos_reg <= -18'(cos_sh);
                sin_reg <= -18'(sin_sh);
            end
            else
            begin
                cos_reg <= 18'(cos_sh);
                sin_reg <= 18'(sin_sh);
            end
        end
        if (cmd.corner_mul)
        begin
            pxc_reg <= dx * cos_reg;
            pys_reg <= dy * sin_reg;
            pxs_reg <= dx * sin_reg;
            pyc_reg <= dy * cos_reg;
        end
        if (cmd.emit_flush)
        begin
            kind_reg <= 1'b0;
            vx_reg   <= '0;
            vy_reg   <= '0;
            tu_reg   <= '0;
            tv_reg   <= '0;
            vcol_reg <= '0;
            vidx_reg <= '0;
            btex_reg <= cur_tex_reg;
            bspr_reg <= count_reg;
            last_reg <= cmd.flush_last;
        end
        else if (cmd.emit_vertex)
        begin
            kind_reg <= 1'b1;
            vx_reg   <= sat32(fin_x);
            vy_reg   <= sat32(fin_y);
            tu_reg   <= ((corner_reg == 2'd1) || (corner_reg == 2'd2)) ? u_sat : uv_reg[15:0];
            tv_reg   <= ((corner_reg == 2'd2) || (corner_reg == 2'd3)) ? v_sat : uv_reg[31:16];
            vcol_reg <= color_reg;
            vidx_reg <= {count_reg[9:0], corner_reg};
            btex_reg <= tex_reg;
            bspr_reg <= '0;
            last_reg <= (corner_reg == 2'd3);
        end
    end

    // control registers: batch state, counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_tex_reg   <= '0;
            count_reg     <= '0;
            iter_reg      <= '0;
            corner_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.discard)
            begin
                count_reg <= '0;
            end
            if (cmd.emit_flush)
            begin
                cur_tex_reg <= '0;
                count_reg   <= '0;
            end
            if (cmd.scale)
            begin
                cur_tex_reg <= tex_reg;
            end
            if (cmd.pivot)
            begin
                iter_reg   <= '0;
                corner_reg <= '0;
            end
            if (cmd.rot_step)
            begin
                iter_reg <= iter_reg + 1'b1;
            end
            if (cmd.emit_vertex)
            begin
                corner_reg <= corner_reg + 1'b1;
                if (corner_reg == 2'd3)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (ld_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign vert_x        = vx_reg;
    assign vert_y        = vy_reg;
    assign tex_u         = tu_reg;
    assign tex_v         = tv_reg;
    assign vertex_color  = vcol_reg;
    assign vertex_index  = vidx_reg;
    assign batch_texture = btex_reg;
    assign batch_sprites = bspr_reg;
    assign last          = last_reg;

    `include "sprite_quad_batcher_unit_defines.svh"

    `SQB_ASSERT_NOW(a_no_overwrite, ld_out && out_valid_reg, !out_stall, "held item overwritten")
    `SQB_ASSERT_NEXT(a_flush_clears, cmd.emit_flush, (cur_tex_reg == '0) && (count_reg == '0), "flush did not clear batch")
    `SQB_ASSERT_NOW(a_rot_bound, cmd.rot_step, iter_reg < ITER_W'(CORDIC_STEPS), "cordic overran")

endmodule

>>> rtl/sprite_quad_batcher_unit.sv
// sprite quad batcher: one draw item in, flush record and four vertex items out
// throughput: one item at a time, the input stalling outside idle; a rotated sprite is
// held longest by the 24-step cordic unit, while a flush or discard item is done sooner
// reset: asynchronous, clears state machine, output valid, batch count and current texture
module sprite_quad_batcher_unit import sqb_pkg::*;
#(
    parameter int MAX_BATCH = SQB_MAX_BATCH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [15:0]        texture_id,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic [31:0]        size_x,
    input  logic [31:0]        size_y,
    input  logic [31:0]        scale_xy,
    input  logic signed [15:0] origin_x,
    input  logic signed [15:0] origin_y,
    input  logic signed [15:0] angle,
    input  logic [63:0]        uv_rect,
    input  logic [31:0]        color,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic signed [31:0] vert_x,
    output logic signed [31:0] vert_y,
    output logic [15:0]        tex_u,
    output logic [15:0]        tex_v,
    output logic [31:0]        vertex_color,
    output logic [11:0]        vertex_index,
    output logic [15:0]        batch_texture,
    output logic [10:0]        batch_sprites,
    output logic               last
);

    sqb_cmd_t  cmd;
    sqb_stat_t stat;
    logic      idle;

    // input stalls except in idle
    assign in_stall = !idle;

    // controller
    sqb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .idle     (idle),
        .cmd      (cmd)
    );

    // datapath
    sqb_datapath #(
        .MAX_BATCH (MAX_BATCH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .texture_id    (texture_id),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .size_x        (size_x),
        .size_y        (size_y),
        .scale_xy      (scale_xy),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .angle         (angle),
        .uv_rect       (uv_rect),
        .color         (color),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .vert_x        (vert_x),
        .vert_y        (vert_y),
        .tex_u         (tex_u),
        .tex_v         (tex_v),
        .vertex_color  (vertex_color),
        .vertex_index  (vertex_index),
        .batch_texture (batch_texture),
        .batch_sprites (batch_sprites),
        .last          (last)
    );

endmodule
